>>> sv/ppurf_pkg.sv
// ----------------------------------------------------------------------------
// ppurf_pkg
// Shared types and constants for the register port and frame timing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppurf_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // register numbers
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  localparam int DATA_W  = 8;
  localparam int VADDR_W = 14;
  localparam int CNT_W   = 9;

  localparam int SPRITE_BYTES  = 256;
  localparam int PALETTE_BYTES = 32;
  localparam int SPR_AW        = $clog2(SPRITE_BYTES);
  localparam int PAL_AW        = $clog2(PALETTE_BYTES);

  // video address map
  localparam logic [VADDR_W-1:0] NAME_BASE    = 14'h2000;
  localparam logic [VADDR_W-1:0] PALETTE_BASE = 14'h3F00;
  localparam logic [VADDR_W-1:0] ROW_STEP     = 14'd32;
  localparam logic [VADDR_W-1:0] COL_STEP     = 14'd1;

  // frame timing
  localparam logic [CNT_W-1:0] DOTS_PER_LINE   = 9'd341;
  localparam logic [CNT_W-1:0] VBLANK_LINE     = 9'd241;
  localparam logic [CNT_W-1:0] LINES_PER_FRAME = 9'd262;

  // request into the video memory
  typedef struct packed {
    logic                clear;
    logic                write;
    logic [VADDR_W-1:0]  addr;
    logic [DATA_W-1:0]   wdata;
  } vreq_t;

  // timing events if a tick were taken now
  typedef struct packed {
    logic vblank_enter;
    logic frame_wrap;
  } tmg_t;

endpackage

`default_nettype wire

>>> sv/ppurf_ram.sv
// ----------------------------------------------------------------------------
// ppurf_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppurf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> sv/ppurf_timing.sv
// ----------------------------------------------------------------------------
// ppurf_timing
// Dot and line counters; flags vblank entry and frame wrap for the next tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppurf_timing import ppurf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tick_i,
  output tmg_t      evt_o
);

  logic [CNT_W-1:0] dot_q, dot_d;
  logic [CNT_W-1:0] line_q, line_d;
  logic [CNT_W-1:0] dot_inc, line_inc;
  logic             line_end;

  // next counter values
  always_comb begin
    dot_inc  = dot_q + 9'd1;
    line_inc = line_q + 9'd1;
    line_end = (dot_inc == DOTS_PER_LINE);
    evt_o.vblank_enter = line_end && (line_inc == VBLANK_LINE);
    evt_o.frame_wrap   = line_end && (line_inc == LINES_PER_FRAME);
    dot_d  = dot_q;
    line_d = line_q;
    if (tick_i) begin
      if (line_end) begin
        dot_d  = '0;
        line_d = evt_o.frame_wrap ? '0 : line_inc;
      end else begin
        dot_d = dot_inc;
      end
    end
  end

  // counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= '0;
      line_q <= '0;
    end else begin
      dot_q  <= dot_d;
      line_q <= line_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/ppurf_vmem.sv
// ----------------------------------------------------------------------------
// ppurf_vmem
// Video address decode with name table and palette memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppurf_vmem import ppurf_pkg::*; #(
  parameter int NAME_BYTES = 4096,
  localparam int NAME_AW   = $clog2(NAME_BYTES)
) (
  input  wire logic               clk_i,
  input  wire vreq_t              req_i,
  input  wire logic [NAME_AW-1:0] clear_addr_i,
  output logic      [DATA_W-1:0]  rdata_o
);

  typedef enum logic [1:0] {
    REGION_PATTERN,
    REGION_NAME,
    REGION_PALETTE
  } region_e;

  region_e            region, region_q;
  logic [NAME_AW-1:0] name_addr;
  logic [PAL_AW-1:0]  pal_addr, pal_slot;
  logic               name_we, pal_we;
  logic [DATA_W-1:0]  wdata;
  logic [DATA_W-1:0]  name_rdata, pal_rdata;

  // region decode and palette mirror fold
  always_comb begin
    if (req_i.addr < NAME_BASE) begin
      region = REGION_PATTERN;
    end else if (req_i.addr < PALETTE_BASE) begin
      region = REGION_NAME;
    end else begin
      region = REGION_PALETTE;
    end
    pal_slot = req_i.addr[PAL_AW-1:0];
    if (pal_slot[4] && (pal_slot[1:0] == 2'b00)) begin
      pal_slot[4] = 1'b0;
    end
  end

  // memory port muxing, clearing sweep takes priority
  always_comb begin
    name_addr = req_i.clear ? clear_addr_i : req_i.addr[NAME_AW-1:0];
    pal_addr  = req_i.clear ? clear_addr_i[PAL_AW-1:0] : pal_slot;
    name_we   = req_i.clear || (req_i.write && (region == REGION_NAME));
    pal_we    = req_i.clear || (req_i.write && (region == REGION_PALETTE));
    wdata     = req_i.clear ? '0 : req_i.wdata;
  end

  ppurf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NAME_BYTES)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .addr_i  (name_addr),
    .wdata_i (wdata),
    .rdata_o (name_rdata)
  );

  ppurf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PALETTE_BYTES)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .addr_i  (pal_addr),
    .wdata_i (wdata),
    .rdata_o (pal_rdata)
  );

  // region is registered alongside the read data
  always_ff @(posedge clk_i) begin
    region_q <= region;
  end

  // read data select
  always_comb begin
    unique case (region_q)
      REGION_NAME:    rdata_o = name_rdata;
      REGION_PALETTE: rdata_o = pal_rdata;
      default:        rdata_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ppu_register_port_and_frame_timing.sv
// ----------------------------------------------------------------------------
// ppu_register_port_and_frame_timing
// CPU register port, video memory access and dot/line frame timing.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   request  | start_i / busy_o    | kind_i, reg_addr_i, write_data_i
//   result   | valid_o (strobe)    | read_data_o, nmi_pulse_o, frame_done_o,
//            |                     | in_vblank_o
//
// Each request passes the accept edge, which issues the memory read and
// updates the registers, and then ST_FINISH, whose closing edge registers the
// result (the RAMs return registered read data). busy_o is high in ST_FINISH.
// After reset a clearing sweep writes zero to all stores, stepping through
// every name store address with busy_o high.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppu_register_port_and_frame_timing import ppurf_pkg::*; #(
  parameter int NAME_BYTES = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [2:0]        reg_addr_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      read_data_o,
  output logic                   nmi_pulse_o,
  output logic                   frame_done_o,
  output logic                   in_vblank_o
);

  localparam int NAME_AW = $clog2(NAME_BYTES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    SEL_IMM,
    SEL_SPRITE,
    SEL_VBUF
  } sel_e;

  state_e             state_q, state_d;
  logic [NAME_AW-1:0] clr_q, clr_d;
  logic               row_q, row_d;
  logic               nmi_en_q, nmi_en_d;
  logic               vblank_q, vblank_d;
  logic               toggle_q, toggle_d;
  logic [VADDR_W-1:0] vaddr_q, vaddr_d, vstep;
  logic [DATA_W-1:0]  rbuf_q, rbuf_d;
  logic [SPR_AW-1:0]  spr_idx_q, spr_idx_d;
  sel_e               sel_q, sel_d;
  logic [DATA_W-1:0]  imm_q, imm_d;
  logic               nmi_q, nmi_d;
  logic               done_q, done_d;
  logic               accept, clearing, tick, spr_we;
  vreq_t              vreq;
  tmg_t               evt;
  logic [DATA_W-1:0]  vmem_rdata, spr_rdata;
  logic [SPR_AW-1:0]  spr_addr;
  logic [DATA_W-1:0]  spr_wdata;
  logic               spr_ram_we;
  logic [DATA_W-1:0]  result_data;

  assign clearing = (state_q == ST_CLEAR);
  assign accept   = (state_q == ST_IDLE) && start_i;
  assign busy_o   = (state_q != ST_IDLE);
  assign vstep    = vaddr_q + (row_q ? ROW_STEP : COL_STEP);

  // request decode and register updates
  always_comb begin
    row_d      = row_q;
    nmi_en_d   = nmi_en_q;
    vblank_d   = vblank_q;
    toggle_d   = toggle_q;
    vaddr_d    = vaddr_q;
    spr_idx_d  = spr_idx_q;
    sel_d      = SEL_IMM;
    imm_d      = '0;
    nmi_d      = 1'b0;
    done_d     = 1'b0;
    tick       = 1'b0;
    spr_we     = 1'b0;
    vreq.clear = clearing;
    vreq.write = 1'b0;
    vreq.addr  = vaddr_q;
    vreq.wdata = write_data_i;
    if (accept) begin
      unique case (kind_e'(kind_i))
        KIND_READ: begin
          unique case (reg_e'(reg_addr_i))
            REG_STATUS: begin
              imm_d    = {vblank_q, 2'b00, rbuf_q[4:0]};
              vblank_d = 1'b0;
              toggle_d = 1'b0;
            end
            REG_OAM_DATA: sel_d = SEL_SPRITE;
            REG_DATA: begin
              sel_d   = SEL_VBUF;
              vaddr_d = vstep;
            end
            default: ;
          endcase
        end
        KIND_WRITE: begin
          unique case (reg_e'(reg_addr_i))
            REG_CTRL: begin
              row_d    = write_data_i[2];
              nmi_en_d = write_data_i[7];
            end
            REG_OAM_ADDR: spr_idx_d = write_data_i;
            REG_OAM_DATA: begin
              spr_we    = 1'b1;
              spr_idx_d = spr_idx_q + 8'd1;
            end
            REG_SCROLL: toggle_d = ~toggle_q;
            REG_ADDR: begin
              if (!toggle_q) begin
                vaddr_d = {write_data_i[5:0], vaddr_q[7:0]};
              end else begin
                vaddr_d = {vaddr_q[13:8], write_data_i};
              end
              toggle_d = ~toggle_q;
            end
            REG_DATA: begin
              vreq.write = 1'b1;
              vaddr_d    = vstep;
            end
            default: ;
          endcase
        end
        KIND_TICK: begin
          tick = 1'b1;
          if (evt.vblank_enter) begin
            vblank_d = 1'b1;
            nmi_d    = nmi_en_q;
          end else if (evt.frame_wrap) begin
            vblank_d = 1'b0;
            done_d   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result select and read buffer reload
  always_comb begin
    rbuf_d = rbuf_q;
    case (sel_q)
      SEL_SPRITE: result_data = spr_rdata;
      SEL_VBUF:   result_data = rbuf_q;
      default:    result_data = imm_q;
    endcase
    if ((state_q == ST_FINISH) && (sel_q == SEL_VBUF)) begin
      rbuf_d = vmem_rdata;
    end
  end

  // sequencer next state and clearing sweep counter
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == NAME_AW'(NAME_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE:   if (start_i) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sprite memory port
  assign spr_addr   = clearing ? clr_q[SPR_AW-1:0] : spr_idx_q;
  assign spr_ram_we = clearing || spr_we;
  assign spr_wdata  = clearing ? '0 : write_data_i;

  ppurf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SPRITE_BYTES)
  ) u_spr_ram (
    .clk_i   (clk_i),
    .we_i    (spr_ram_we),
    .addr_i  (spr_addr),
    .wdata_i (spr_wdata),
    .rdata_o (spr_rdata)
  );

  ppurf_vmem #(
    .NAME_BYTES (NAME_BYTES)
  ) u_vmem (
    .clk_i        (clk_i),
    .req_i        (vreq),
    .clear_addr_i (clr_q),
    .rdata_o      (vmem_rdata)
  );

  ppurf_timing u_timing (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .evt_o  (evt)
  );

  // state, registers and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      row_q        <= 1'b0;
      nmi_en_q     <= 1'b0;
      vblank_q     <= 1'b0;
      toggle_q     <= 1'b0;
      vaddr_q      <= '0;
      rbuf_q       <= '0;
      spr_idx_q    <= '0;
      sel_q        <= SEL_IMM;
      imm_q        <= '0;
      nmi_q        <= 1'b0;
      done_q       <= 1'b0;
      valid_o      <= 1'b0;
      read_data_o  <= '0;
      nmi_pulse_o  <= 1'b0;
      frame_done_o <= 1'b0;
      in_vblank_o  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      row_q     <= row_d;
      nmi_en_q  <= nmi_en_d;
      vblank_q  <= vblank_d;
      toggle_q  <= toggle_d;
      vaddr_q   <= vaddr_d;
      rbuf_q    <= rbuf_d;
      spr_idx_q <= spr_idx_d;
      if (accept) begin
        sel_q  <= sel_d;
        imm_q  <= imm_d;
        nmi_q  <= nmi_d;
        done_q <= done_d;
      end
      valid_o <= (state_q == ST_FINISH);
      if (state_q == ST_FINISH) begin
        read_data_o  <= result_data;
        nmi_pulse_o  <= nmi_q;
        frame_done_o <= done_q;
        in_vblank_o  <= vblank_q;
      end
    end
  end

`ifndef ASSERT_OFF
  // every accepted request yields its result once ST_FINISH has been passed
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 valid_o)
    else $error("accepted request produced no result");

  // results never come back to back
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for two cycles");

  // an nmi pulse only comes with vblank set
  a_nmi_in_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && nmi_pulse_o) |-> in_vblank_o)
    else $error("nmi pulse outside vblank");

  // frame wrap always leaves vblank clear
  a_frame_clears_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && frame_done_o) |-> (!in_vblank_o && !nmi_pulse_o))
    else $error("frame wrap with vblank still set");
`endif

endmodule

`default_nettype wire

>>> tb/tb_ppu_register_port_and_frame_timing.sv
// ----------------------------------------------------------------------------
// tb_ppu_register_port_and_frame_timing
// Self-checking bench for the register port and frame timing block. Requests
// (register reads, register writes, dot ticks) go in through start/busy with
// random idle gaps. A cycle-free model of the port predicts each result
// strobe, and the results are compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_ppu_register_port_and_frame_timing;
  import ppurf_pkg::*;

  localparam int NAME_BYTES     = 4096;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int MAX_IDLE       = 13;

  // one result strobe as predicted
  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              nmi_pulse;
    logic              frame_done;
    logic              in_vblank;
  } port_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        kind_i;
  logic [2:0]        reg_addr_i;
  logic [DATA_W-1:0] write_data_i;
  logic              valid_o;
  logic [DATA_W-1:0] read_data_o;
  logic              nmi_pulse_o;
  logic              frame_done_o;
  logic              in_vblank_o;

  ppu_register_port_and_frame_timing #(
    .NAME_BYTES (NAME_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .valid_o      (valid_o),
    .read_data_o  (read_data_o),
    .nmi_pulse_o  (nmi_pulse_o),
    .frame_done_o (frame_done_o),
    .in_vblank_o  (in_vblank_o)
  );

  // port model state, all zero after reset
  bit                row_step;
  bit                nmi_en;
  bit                vblank;
  bit                toggle;
  bit [VADDR_W-1:0]  vaddr;
  bit [DATA_W-1:0]   rd_buffer;
  bit [SPR_AW-1:0]   oam_idx;
  bit [CNT_W-1:0]    dot_cnt;
  bit [CNT_W-1:0]    line_cnt;
  bit [DATA_W-1:0]   name_mem [NAME_BYTES];
  bit [DATA_W-1:0]   pal_mem  [PALETTE_BYTES];
  bit [DATA_W-1:0]   oam_mem  [SPRITE_BYTES];

  port_result_t port_results_due[$];

  bit          no_idle;
  int unsigned n_mismatch;
  int unsigned n_effective;
  int unsigned n_reads, n_writes, n_ticks, n_other;
  int unsigned n_nmi, n_frames, n_vblank_reads;
  int unsigned stall_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // video memory map: pattern space, name store, folded palette
  function automatic logic [DATA_W-1:0] vmem_access(input logic [VADDR_W-1:0] a,
                                                    input bit wr,
                                                    input logic [DATA_W-1:0] v);
    logic [PAL_AW-1:0] p;
    int unsigned       ni;
    p  = a[PAL_AW-1:0];
    ni = int'(a[11:0]) & (NAME_BYTES - 1);
    if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
    if (a < NAME_BASE) return '0;
    if (a < PALETTE_BASE) begin
      if (wr) name_mem[ni] = v;
      return name_mem[ni];
    end
    if (wr) pal_mem[p] = v;
    return pal_mem[p];
  endfunction

  // advance the port model by one request and return its result
  function automatic port_result_t ppu_port_step(input kind_e k, input reg_e r,
                                                 input logic [DATA_W-1:0] d);
    port_result_t res;
    res = '{read_data: '0, nmi_pulse: 1'b0, frame_done: 1'b0, in_vblank: 1'b0};
    case (k)
      KIND_READ: begin
        case (r)
          REG_STATUS: begin
            res.read_data = {vblank, 2'b00, rd_buffer[4:0]};
            vblank = 1'b0;
            toggle = 1'b0;
          end
          REG_OAM_DATA: res.read_data = oam_mem[oam_idx];
          REG_DATA: begin
            res.read_data = rd_buffer;
            rd_buffer = vmem_access(vaddr, 1'b0, '0);
            vaddr = vaddr + (row_step ? ROW_STEP : COL_STEP);
          end
          default: ;
        endcase
      end
      KIND_WRITE: begin
        case (r)
          REG_CTRL: begin
            row_step = d[2];
            nmi_en   = d[7];
          end
          REG_OAM_ADDR: oam_idx = d;
          REG_OAM_DATA: begin
            oam_mem[oam_idx] = d;
            oam_idx = oam_idx + 1'b1;
          end
          REG_SCROLL: toggle = ~toggle;
          REG_ADDR: begin
            if (!toggle) vaddr = {d[5:0], vaddr[7:0]};
            else vaddr = {vaddr[13:8], d};
            toggle = ~toggle;
          end
          REG_DATA: begin
            void'(vmem_access(vaddr, 1'b1, d));
            vaddr = vaddr + (row_step ? ROW_STEP : COL_STEP);
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        dot_cnt = dot_cnt + 1'b1;
        if (dot_cnt >= DOTS_PER_LINE) begin
          dot_cnt  = '0;
          line_cnt = line_cnt + 1'b1;
          if (line_cnt == VBLANK_LINE) begin
            vblank        = 1'b1;
            res.nmi_pulse = nmi_en;
          end else if (line_cnt >= LINES_PER_FRAME) begin
            line_cnt       = '0;
            res.frame_done = 1'b1;
            vblank         = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.in_vblank = vblank;
    return res;
  endfunction

  // send one request, predict its result once accepted
  task automatic send_request(input kind_e k, input logic [2:0] r,
                              input logic [DATA_W-1:0] d);
    int unsigned  gap;
    port_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    kind_i       <= k;
    reg_addr_i   <= r;
    write_data_i <= d;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    res = ppu_port_step(k, reg_e'(r), d);
    port_results_due.push_back(res);
    // bookkeeping for the summary
    case (k)
      KIND_READ:  n_reads++;
      KIND_WRITE: n_writes++;
      KIND_TICK:  n_ticks++;
      default:    n_other++;
    endcase
    if (res.nmi_pulse) n_nmi++;
    if (res.frame_done) n_frames++;
    if (k == KIND_READ && reg_e'(r) == REG_STATUS && res.read_data[7]) n_vblank_reads++;
    if (!(k == KIND_NONE ||
          (k == KIND_READ && r inside {REG_CTRL, REG_MASK, REG_OAM_ADDR, REG_SCROLL,
                                       REG_ADDR}) ||
          (k == KIND_WRITE && r inside {REG_MASK, REG_STATUS})))
      n_effective++;
    @(negedge clk_i);
  endtask

  // hold off until every predicted result has come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (port_results_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // back-to-back ticks up to a given line and dot
  task automatic ticks_until(input int unsigned to_line, input int unsigned to_dot);
    bit saved;
    saved   = no_idle;
    no_idle = 1'b1;
    while (line_cnt != to_line || dot_cnt != to_dot)
      send_request(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    no_idle = saved;
  endtask

  // result checker
  always @(posedge clk_i) begin
    port_result_t want;
    if (rst_ni && valid_o) begin
      if (port_results_due.size() == 0) begin
        $error("result strobe with no request outstanding");
        n_mismatch++;
      end else begin
        want = port_results_due.pop_front();
        if (read_data_o !== want.read_data) begin
          $error("read_data: expected %02h, got %02h", want.read_data, read_data_o);
          n_mismatch++;
        end
        if (nmi_pulse_o !== want.nmi_pulse) begin
          $error("nmi_pulse: expected %0b, got %0b", want.nmi_pulse, nmi_pulse_o);
          n_mismatch++;
        end
        if (frame_done_o !== want.frame_done) begin
          $error("frame_done: expected %0b, got %0b", want.frame_done, frame_done_o);
          n_mismatch++;
        end
        if (in_vblank_o !== want.in_vblank) begin
          $error("in_vblank: expected %0b, got %0b", want.in_vblank, in_vblank_o);
          n_mismatch++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken and no result seen
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_ppu_register_port_and_frame_timing: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // registers straight out of reset, plus an unused kind
  task automatic test_reset_values();
    send_request(KIND_READ, REG_STATUS, 8'h00);
    send_request(KIND_READ, REG_OAM_DATA, 8'hFF);
    send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_READ, REG_CTRL, 8'hFF);
    send_request(KIND_NONE, REG_DATA, 8'hFF);
  endtask

  // sprite index wrap, toggle sharing, address wrap, palette fold, read buffer
  task automatic test_register_access();
    send_request(KIND_WRITE, REG_OAM_ADDR, 8'hFF);
    send_request(KIND_WRITE, REG_OAM_DATA, 8'h5A);
    send_request(KIND_WRITE, REG_OAM_DATA, 8'hFF);
    send_request(KIND_WRITE, REG_OAM_ADDR, 8'hFF);
    send_request(KIND_READ, REG_OAM_DATA, 8'h00);
    // scroll write leaves the toggle set, so the low byte lands first
    send_request(KIND_WRITE, REG_SCROLL, 8'h00);
    send_request(KIND_WRITE, REG_ADDR, 8'hFF);
    send_request(KIND_WRITE, REG_ADDR, 8'h7F);
    send_request(KIND_WRITE, REG_CTRL, 8'hFF);
    // top palette entry, then the address wraps into pattern space
    send_request(KIND_WRITE, REG_DATA, 8'h11);
    send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_READ, REG_DATA, 8'h00);
    // mirrored palette slot and the delayed read back
    send_request(KIND_READ, REG_STATUS, 8'h00);
    send_request(KIND_WRITE, REG_ADDR, 8'h3F);
    send_request(KIND_WRITE, REG_ADDR, 8'h10);
    send_request(KIND_WRITE, REG_CTRL, 8'h00);
    send_request(KIND_WRITE, REG_DATA, 8'hC3);
    send_request(KIND_WRITE, REG_ADDR, 8'h3F);
    send_request(KIND_WRITE, REG_ADDR, 8'h00);
    send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_READ, REG_DATA, 8'h00);
    drain_results();
  endtask

  // dot counter through the first line wrap with nmi enabled, status outside vblank
  task automatic test_frame_timing();
    send_request(KIND_WRITE, REG_CTRL, 8'h80);
    ticks_until(0, 338);
    repeat (5) send_request(KIND_TICK, REG_CTRL, 8'h00);
    send_request(KIND_READ, REG_STATUS, 8'h00);
    send_request(KIND_READ, REG_STATUS, 8'h00);
    send_request(KIND_WRITE, REG_CTRL, 8'h00);
  endtask

  // random sequences, mostly well formed address/data and sprite traffic
  task automatic test_random_traffic();
    int unsigned       first;
    int unsigned       n;
    logic [DATA_W-1:0] hi, lo, idx;
    first = n_effective;
    while (n_effective - first < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // top two bits of the high byte are dropped by the block
          hi = 8'($urandom_range(0, 255));
          lo = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 4))
            0: hi[5:0] = 6'h3F;
            1: hi[5:0] = 6'h3E;
            2: hi[5:0] = 6'($urandom_range(6'h20, 6'h2F));
            3: hi[5:0] = 6'($urandom_range(6'h00, 6'h1F));
            default: ;
          endcase
          n = $urandom_range(1, 6);
          send_request(KIND_READ, REG_STATUS, 8'($urandom_range(0, 255)));
          send_request(KIND_WRITE, REG_ADDR, hi);
          send_request(KIND_WRITE, REG_ADDR, lo);
          repeat (n)
            send_request($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, REG_DATA,
                         8'($urandom_range(0, 255)));
          // read back through the buffered port
          send_request(KIND_READ, REG_STATUS, 8'($urandom_range(0, 255)));
          send_request(KIND_WRITE, REG_ADDR, hi);
          send_request(KIND_WRITE, REG_ADDR, lo);
          repeat (n + 1) send_request(KIND_READ, REG_DATA, 8'($urandom_range(0, 255)));
        end
        3: begin
          idx = 8'($urandom_range(0, 255));
          n   = $urandom_range(1, 5);
          send_request(KIND_WRITE, REG_OAM_ADDR, idx);
          repeat (n) send_request(KIND_WRITE, REG_OAM_DATA, 8'($urandom_range(0, 255)));
          for (int unsigned i = 0; i < n; i++) begin
            send_request(KIND_WRITE, REG_OAM_ADDR, idx + i[7:0]);
            send_request(KIND_READ, REG_OAM_DATA, 8'($urandom_range(0, 255)));
          end
        end
        4: send_request(KIND_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
        5: begin
          repeat ($urandom_range(1, 24))
            send_request(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
        6: begin
          // scroll and address writes fighting over the toggle
          repeat ($urandom_range(1, 4))
            send_request(KIND_WRITE, $urandom_range(0, 1) ? REG_SCROLL : REG_ADDR,
                         8'($urandom_range(0, 255)));
        end
        7: begin
          repeat ($urandom_range(1, 4))
            send_request(kind_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
        end
        8: begin
          repeat ($urandom_range(1, 3))
            send_request(KIND_READ, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
        default: begin
          if ($urandom_range(0, 3) == 0) drain_results();
          else send_request(KIND_TICK, 3'($urandom_range(0, 7)),
                            8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // test sequence
  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = KIND_READ;
    reg_addr_i   = REG_CTRL;
    write_data_i = '0;
    no_idle      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_register_access();
    test_frame_timing();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("requests: %0d reads, %0d writes, %0d ticks, %0d unused kind",
             n_reads, n_writes, n_ticks, n_other);
    $display("frame events: %0d nmi pulses, %0d frame wraps, %0d status reads in vblank",
             n_nmi, n_frames, n_vblank_reads);
    if (n_mismatch == 0) begin
      $display("tb_ppu_register_port_and_frame_timing: clean");
    end else begin
      $display("tb_ppu_register_port_and_frame_timing: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/ppurf_pkg.sv
sv/ppurf_ram.sv
sv/ppurf_timing.sv
sv/ppurf_vmem.sv
sv/ppu_register_port_and_frame_timing.sv
tb/tb_ppu_register_port_and_frame_timing.sv
